// ----- hw/rtl/sh_irr_pkg.sv -----
// Shared constants, codes and the pipeline beat type of the SH irradiance evaluator.
package sh_irr_pkg;

    // Field widths
    localparam int COEF_WIDTH   = 32;
    localparam int NORMAL_WIDTH = 16;
    localparam int TERM_W       = 4;
    localparam int CHN_W        = 2;
    localparam int OUT_W        = 32;

    // Basis geometry
    localparam int NUM_TERMS = 9;
    localparam int NUM_CHN   = 3;

    // Fixed-point layout: normals are Q1.NFRAC, basis and results are Q.16
    localparam int FRAC_OUT = 16;
    localparam int NFRAC    = NORMAL_WIDTH - 2;
    localparam int QSH      = 2 * NFRAC - FRAC_OUT;
    localparam int QRND     = (QSH == 0) ? 0 : (1 << (QSH - 1));
    localparam int LRND     = 1 << (NFRAC - 1);
    localparam int HALF16   = 1 << (FRAC_OUT - 1);
    localparam int ONE_Q16  = 1 << FRAC_OUT;

    // Value ranges: linear terms stay within 17 bits, rounded component
    // products within 2^18, basis values within 20 bits, whatever NORMAL_WIDTH.
    localparam int CONST_W = 18;
    localparam int LIN_W   = 18;
    localparam int QUAD_W  = 20;
    localparam int BASIS_W = 21;
    localparam int PROD_W  = COEF_WIDTH + BASIS_W;
    localparam int ACC_W   = PROD_W + 4;

    // Basis constants in Q.16, rounded to nearest
    localparam logic signed [CONST_W-1:0] K_C0 = 18'sd18487;
    localparam logic signed [CONST_W-1:0] K_C1 = 18'sd32021;
    localparam logic signed [CONST_W-1:0] K_C2 = 18'sd71601;
    localparam logic signed [CONST_W-1:0] K_C3 = 18'sd20670;
    localparam logic signed [CONST_W-1:0] K_C4 = 18'sd35801;

    // Accumulator seed carries the final round-to-nearest half
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(HALF16);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

    // Operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    // Channel code that names no channel
    localparam logic [CHN_W-1:0] CHN_NONE = 2'd3;

    // One beat moving down the row of term cells
    typedef struct packed {
        logic                                 eval;
        logic [TERM_W-1:0]                    idx;
        logic [CHN_W-1:0]                     chn;
        logic [COEF_WIDTH-1:0]                val;
        logic [NUM_TERMS-1:0][BASIS_W-1:0]    basis;
        logic [NUM_CHN-1:0][ACC_W-1:0]        acc;
        logic [NUM_CHN-1:0][PROD_W-1:0]       prod;
    } t_beat;

endpackage

// ----- hw/rtl/sh_irradiance_eval.sv -----
// Top level of the nine-term spherical-harmonic RGB irradiance evaluator.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_op, i_coef_index, i_color_channel,
//                                            i_coef_value, i_normal_x/y/z
//   result    out        o_valid / i_stall   o_irr_red, o_irr_green, o_irr_blue
//
// One beat per cycle while the sink does not stall, loads and evaluates alike; an evaluate
// result passes through 2 basis stages, 9 term cells and 1 output register after acceptance.
// Loads travel the same row of cells and write as they pass their term's cell,
// so every evaluate sees exactly the loads accepted before it.
// Reset clears all valid bits and the 27 coefficients at once; no clearing pass.
// A stall holds the output register; upstream stages keep filling empty slots
// until the row is full, then o_stall rises.
module sh_irradiance_eval import sh_irr_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [TERM_W-1:0]              i_coef_index,
    input  logic [CHN_W-1:0]               i_color_channel,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_value,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_x,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_y,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_z,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [OUT_W-1:0]        o_irr_red,
    output logic signed [OUT_W-1:0]        o_irr_green,
    output logic signed [OUT_W-1:0]        o_irr_blue
);

    logic                basis_ready;
    logic  [NUM_TERMS:0] row_valid;
    logic  [NUM_TERMS:0] row_ready;
    t_beat               row_beat [NUM_TERMS+1];

    assign o_stall = !basis_ready;

    // Basis front end
    sh_irr_basis u_basis (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (basis_ready),
        .i_op            (i_op),
        .i_coef_index    (i_coef_index),
        .i_color_channel (i_color_channel),
        .i_coef_value    (i_coef_value),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_normal_z      (i_normal_z),
        .o_valid         (row_valid[0]),
        .o_beat          (row_beat[0]),
        .i_ready         (row_ready[0])
    );

    // Row of term cells, one per basis term
    for (genvar k = 0; k < NUM_TERMS; k++) begin : g_cell
        sh_irr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_term  (TERM_W'(k)),
            .i_valid (row_valid[k]),
            .o_ready (row_ready[k]),
            .i_beat  (row_beat[k]),
            .o_valid (row_valid[k+1]),
            .o_beat  (row_beat[k+1]),
            .i_ready (row_ready[k+1])
        );
    end

    // Output stage
    sh_irr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (row_valid[NUM_TERMS]),
        .o_ready     (row_ready[NUM_TERMS]),
        .i_beat      (row_beat[NUM_TERMS]),
        .o_valid     (o_valid),
        .o_irr_red   (o_irr_red),
        .o_irr_green (o_irr_green),
        .o_irr_blue  (o_irr_blue),
        .i_stall     (i_stall)
    );

`ifndef SYNTHESIS
    // Input side stalls only while the output register is full and held
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the output register");
`endif

endmodule

// ----- hw/rtl/sh_irr_basis.sv -----
// Two-stage front end that forms the nine SH basis values of a normal.
module sh_irr_basis import sh_irr_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [TERM_W-1:0]              i_coef_index,
    input  logic [CHN_W-1:0]               i_color_channel,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_value,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_x,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_y,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_z,
    output logic                           o_valid,
    output t_beat                          o_beat,
    input  logic                           i_ready
);

    localparam int NP_W = 2 * NORMAL_WIDTH;
    localparam int LP_W = CONST_W + NORMAL_WIDTH;
    localparam int EX_W = QUAD_W + 3;
    localparam int SP_W = CONST_W + EX_W;

    typedef struct packed {
        logic                       eval;
        logic [TERM_W-1:0]          idx;
        logic [CHN_W-1:0]           chn;
        logic [COEF_WIDTH-1:0]      val;
        logic signed [LIN_W-1:0]    lx;
        logic signed [LIN_W-1:0]    ly;
        logic signed [LIN_W-1:0]    lz;
        logic signed [QUAD_W-1:0]   xy;
        logic signed [QUAD_W-1:0]   yz;
        logic signed [QUAD_W-1:0]   xz;
        logic signed [QUAD_W-1:0]   xx;
        logic signed [QUAD_W-1:0]   yy;
        logic signed [QUAD_W-1:0]   zz;
    } t_front;

    // Component product rounded to Q.16
    function automatic logic signed [QUAD_W-1:0] quad_q16(
        input logic signed [NORMAL_WIDTH-1:0] a,
        input logic signed [NORMAL_WIDTH-1:0] b
    );
        logic signed [NP_W-1:0] p;
        p = NP_W'(a) * NP_W'(b);
        return QUAD_W'((p + NP_W'(QRND)) >>> QSH);
    endfunction

    // Constant times component rounded to Q.16
    function automatic logic signed [LIN_W-1:0] lin_q16(
        input logic signed [NORMAL_WIDTH-1:0] a
    );
        logic signed [LP_W-1:0] p;
        p = LP_W'(K_C1) * LP_W'(a);
        return LIN_W'((p + LP_W'(LRND)) >>> NFRAC);
    endfunction

    // Constant times Q.16 value rounded to Q.16
    function automatic logic signed [BASIS_W-1:0] scale_q16(
        input logic signed [EX_W-1:0]    v,
        input logic signed [CONST_W-1:0] k
    );
        logic signed [SP_W-1:0] p;
        p = SP_W'(k) * SP_W'(v);
        return BASIS_W'((p + SP_W'(HALF16)) >>> FRAC_OUT);
    endfunction

    t_front                  r_a;
    t_front                  n_a;
    logic                    r_va;
    t_beat                   r_b;
    t_beat                   n_b;
    logic                    r_vb;
    logic                    rdy_a;
    logic                    rdy_b;
    logic signed [EX_W-1:0]  t6;
    logic signed [EX_W-1:0]  t8;

    // Stage readiness: a stage takes a beat when empty or draining
    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_beat  = r_b;

    // Stage A: component products and linear terms
    always_comb begin
        n_a.eval = (i_op == OP_EVAL);
        n_a.idx  = i_coef_index;
        n_a.chn  = i_color_channel;
        n_a.val  = i_coef_value;
        n_a.lx   = lin_q16(i_normal_x);
        n_a.ly   = lin_q16(i_normal_y);
        n_a.lz   = lin_q16(i_normal_z);
        n_a.xy   = quad_q16(i_normal_x, i_normal_y);
        n_a.yz   = quad_q16(i_normal_y, i_normal_z);
        n_a.xz   = quad_q16(i_normal_x, i_normal_z);
        n_a.xx   = quad_q16(i_normal_x, i_normal_x);
        n_a.yy   = quad_q16(i_normal_y, i_normal_y);
        n_a.zz   = quad_q16(i_normal_z, i_normal_z);
    end

    // Stage B: scaled quadratic terms and the full basis vector
    always_comb begin
        t6 = EX_W'(r_a.zz) + (EX_W'(r_a.zz) <<< 1) - EX_W'(ONE_Q16);
        t8 = EX_W'(r_a.xx) - EX_W'(r_a.yy);
        n_b.eval     = r_a.eval;
        n_b.idx      = r_a.idx;
        n_b.chn      = r_a.chn;
        n_b.val      = r_a.val;
        n_b.basis[0] = BASIS_W'(K_C0);
        n_b.basis[1] = BASIS_W'(r_a.ly);
        n_b.basis[2] = BASIS_W'(r_a.lz);
        n_b.basis[3] = BASIS_W'(r_a.lx);
        n_b.basis[4] = scale_q16(EX_W'(r_a.xy), K_C2);
        n_b.basis[5] = scale_q16(EX_W'(r_a.yz), K_C2);
        n_b.basis[6] = scale_q16(t6, K_C3);
        n_b.basis[7] = scale_q16(EX_W'(r_a.xz), K_C2);
        n_b.basis[8] = scale_q16(t8, K_C4);
        for (int c = 0; c < NUM_CHN; c++) begin
            n_b.acc[c]  = ACC_RND;
            n_b.prod[c] = '0;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a <= n_a;
        end
        if (rdy_b) begin
            r_b <= n_b;
        end
    end

endmodule

// ----- hw/rtl/sh_irr_cell.sv -----
// One term cell: holds one basis term's three channel coefficients and forms its products.
module sh_irr_cell import sh_irr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TERM_W-1:0] i_term,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_beat             i_beat,
    output logic              o_valid,
    output t_beat             o_beat,
    input  logic              i_ready
);

    logic [NUM_CHN-1:0][COEF_WIDTH-1:0] r_coef;
    logic                               r_valid;
    t_beat                              r_beat;
    t_beat                              n_beat;
    logic                               take;
    logic                               wr_hit;
    logic signed [BASIS_W-1:0]          basis_sel;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;
    assign take    = i_valid && o_ready;

    // A load beat that names this term and a real channel writes one coefficient
    assign wr_hit = take && !i_beat.eval && (i_beat.idx == i_term) && (i_beat.chn != CHN_NONE);

    assign basis_sel = $signed(i_beat.basis[i_term]);

    // Fold the previous cell's product in and form this term's products
    always_comb begin
        n_beat = i_beat;
        for (int c = 0; c < NUM_CHN; c++) begin
            n_beat.acc[c]  = $signed(i_beat.acc[c]) + ACC_W'($signed(i_beat.prod[c]));
            n_beat.prod[c] = PROD_W'($signed(r_coef[c])) * PROD_W'(basis_sel);
        end
    end

    // Coefficient store for this term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (wr_hit) begin
            r_coef[i_beat.chn] <= i_beat.val;
        end
    end

    // Hand the beat to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_beat <= n_beat;
        end
    end

`ifndef SYNTHESIS
    // Evaluate beats never touch the store
    a_eval_keeps_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_beat.eval |=> $stable(r_coef))
        else $error("coefficient changed on an evaluate beat");

    // Loads for another term or no channel are dropped here
    a_miss_keeps_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_beat.eval && ((i_beat.idx != i_term) || (i_beat.chn == CHN_NONE))
        |=> $stable(r_coef))
        else $error("coefficient changed on a load for another slot");
`endif

endmodule

// ----- hw/rtl/sh_irr_out.sv -----
// Final sum, rounding and saturation of the three channel results into the output register.
module sh_irr_out import sh_irr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_beat                   i_beat,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_irr_red,
    output logic signed [OUT_W-1:0] o_irr_green,
    output logic signed [OUT_W-1:0] o_irr_blue,
    input  logic                    i_stall
);

    logic                          r_valid;
    logic [NUM_CHN-1:0][OUT_W-1:0] r_irr;
    logic [NUM_CHN-1:0][OUT_W-1:0] n_irr;
    logic signed [ACC_W-1:0]       total;
    logic signed [ACC_W-1:0]       shifted;

    assign o_ready     = !r_valid || !i_stall;
    assign o_valid     = r_valid;
    assign o_irr_red   = $signed(r_irr[0]);
    assign o_irr_green = $signed(r_irr[1]);
    assign o_irr_blue  = $signed(r_irr[2]);

    // Add the last product, drop the fraction, clamp to 32 bits
    always_comb begin
        total   = '0;
        shifted = '0;
        for (int c = 0; c < NUM_CHN; c++) begin
            total   = $signed(i_beat.acc[c]) + ACC_W'($signed(i_beat.prod[c]));
            shifted = total >>> FRAC_OUT;
            if (shifted > SAT_MAX) begin
                n_irr[c] = OUT_W'(SAT_MAX);
            end else if (shifted < SAT_MIN) begin
                n_irr[c] = OUT_W'(SAT_MIN);
            end else begin
                n_irr[c] = OUT_W'(shifted);
            end
        end
    end

    // Keep evaluate beats, drop load beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && i_beat.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_irr <= n_irr;
        end
    end

`ifndef SYNTHESIS
    // A held result is not lost while the sink stalls
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");

    // A load beat yields no result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_beat.eval |=> !o_valid)
        else $error("result produced by a load beat");
`endif

endmodule
